// ===== rtl/core/fuzzy_min_max_centroid_inference_macros.svh =====
// assertion macros shared by the fuzzy inference rtl
// expects clk and rst_n in the scope of each use
`ifndef FUZZY_MIN_MAX_CENTROID_INFERENCE_MACROS_SVH
`define FUZZY_MIN_MAX_CENTROID_INFERENCE_MACROS_SVH

// consequent checked in the same cycle
`define FMMC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define FMMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fmmc_pkg.sv =====
// shared types, constants and the bell shape table for the fuzzy inference engine
// no dependencies
package fmmc_pkg;

    localparam int NUM_SETS_DEF    = 16;
    localparam int MAX_RULES_DEF   = 16;
    localparam int MAX_SAMPLES_DEF = 512;

    localparam int BELL_SIZE  = 1024;
    localparam int BELL_AW    = 10;
    localparam int BELL_TERMS = 17;

    localparam int MF_DW      = 30;
    localparam int MF_QW      = 17;
    localparam int TRI_STEPS  = 17;
    localparam int BELL_STEPS = 12;
    localparam int CTR_QW     = 15;

    localparam logic [15:0] ONE_Q15      = 16'd32768;
    localparam logic [15:0] CENTROID_MAX = 16'd32767;
    localparam logic [14:0] STEP_RESET   = 15'd13;
    localparam logic [9:0]  COUNT_RESET  = 10'd300;

    localparam logic [1:0] FUNC_LOAD_MF   = 2'd0;
    localparam logic [1:0] FUNC_LOAD_RULE = 2'd1;
    localparam logic [1:0] FUNC_INFER     = 2'd2;

    localparam logic [1:0] CFG_RULE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_STEP  = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd2;

    typedef struct packed {
        logic               shape;
        logic [14:0]        width;
        logic signed [15:0] center;
        logic [15:0]        peak;
    } mship_t;

    typedef struct packed {
        logic [3:0] first;
        logic [3:0] second;
        logic [3:0] outset;
    } rule_t;

    typedef struct packed {
        logic   start;
        mship_t entry;
    } mf_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] degree;
    } mf_rsp_t;

    typedef logic [15:0] bell_rom_t [BELL_SIZE];

    // floor(num / den) by shift and subtract, dividend below 2^48
    function automatic longint unsigned div_small(longint unsigned num, longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int b = 47; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // (1-s)exp(-s) in q1.15, exp from a truncated alternating series in q32
    function automatic bell_rom_t build_bell();
        bell_rom_t       rom;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned f;
        for (int i = 0; i < BELL_SIZE; i++)
        begin
            term = 64'd1 << 32;
            sum  = term;
            for (int k = 1; k < BELL_TERMS; k++)
            begin
                term = div_small((term * longint'(i)) >> BELL_AW, longint'(k));
                if ((k & 1) == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            f = (sum * longint'(BELL_SIZE - i)) >> BELL_AW;
            f = (f + (64'd1 << 16)) >> 17;
            if (f > 64'd32768)
            begin
                f = 64'd32768;
            end
            rom[i] = 16'(f);
        end
        return rom;
    endfunction

    localparam bell_rom_t BELL_ROM = build_bell();

endpackage

// ===== rtl/core/fmmc_div.sv =====
// restoring divider, one quotient bit per cycle
// caller gives a partial remainder below the divisor; uses no package
module fmmc_div #(
    parameter int DW = 30,
    parameter int QW = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DW-1:0]            den,
    input  logic [DW-1:0]            rem_init,
    input  logic [QW-1:0]            lo_init,
    input  logic [$clog2(QW+1)-1:0]  steps,
    output logic                     busy,
    output logic                     done,
    output logic [QW-1:0]            quo
);
    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] lo_reg, lo_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        trial     = {rem_reg, lo_reg[QW-1]};
        den_next  = den_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            den_next  = den;
            rem_next  = rem_init;
            lo_next   = lo_init;
            quo_next  = '0;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            lo_next = {lo_reg[QW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DW'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/core/fmmc_mf.sv =====
// membership degree unit: triangle or bell degree of one set at one point
// uses fmmc_pkg and fmmc_div
module fmmc_mf #(
    parameter int XBITS = 25
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fmmc_pkg::mf_req_t       req,
    input  logic signed [XBITS-1:0] x,
    output fmmc_pkg::mf_rsp_t       rsp
);
    import fmmc_pkg::*;

    localparam int SCW = $clog2(MF_QW + 1);

    typedef enum logic [6:0] {
        MF_IDLE  = 7'b0000001,
        MF_CMP   = 7'b0000010,
        MF_MUL   = 7'b0000100,
        MF_DIV   = 7'b0001000,
        MF_ROM   = 7'b0010000,
        MF_SCALE = 7'b0100000,
        MF_POST  = 7'b1000000
    } mf_state_t;

    mf_state_t            state_reg, state_next;
    mship_t               ent_reg, ent_next;
    logic [XBITS:0]       d_reg, d_next;
    logic [31:0]          prod_reg, prod_next;
    logic [15:0]          deg_reg, deg_next;
    logic                 done_reg, done_next;
    logic [15:0]          rom_reg;
    logic signed [XBITS:0] diff;
    logic [14:0]          d15;
    logic [15:0]          mul_a, mul_b;
    logic [29:0]          w_sq;
    logic                 div_start, div_done;
    logic [MF_DW-1:0]     div_den, div_rem;
    logic [MF_QW-1:0]     div_lo, div_quo;
    logic [SCW-1:0]       div_steps;
    logic [MF_QW-1:0]     peak_ext;

    assign diff     = (XBITS+1)'(x) - (XBITS+1)'(req.entry.center);
    assign d15      = d_reg[14:0];
    assign w_sq     = ent_reg.width * ent_reg.width;
    assign peak_ext = MF_QW'(ent_reg.peak);

    always_comb
    begin
        state_next = state_reg;
        ent_next   = ent_reg;
        d_next     = d_reg;
        prod_next  = prod_reg;
        deg_next   = deg_reg;
        done_next  = 1'b0;
        div_start  = 1'b0;
        mul_a      = ent_reg.shape ? {1'b0, d15} : ent_reg.peak;
        mul_b      = {1'b0, d15};
        // bell: d*d*4096 / w*w; triangle: 2*p*d / w
        div_den    = ent_reg.shape ? w_sq : MF_DW'(ent_reg.width);
        div_rem    = ent_reg.shape ? prod_reg[29:0] : MF_DW'(prod_reg[30:16]);
        div_lo     = ent_reg.shape ? '0 : {prod_reg[15:0], 1'b0};
        div_steps  = ent_reg.shape ? SCW'(BELL_STEPS) : SCW'(TRI_STEPS);
        case (state_reg)
            MF_IDLE:
            begin
                if (req.start)
                begin
                    ent_next   = req.entry;
                    d_next     = diff[XBITS] ? (XBITS+1)'(-diff) : (XBITS+1)'(diff);
                    state_next = MF_CMP;
                end
            end
            MF_CMP:
            begin
                if (d_reg >= (XBITS+1)'(ent_reg.width))
                begin
                    deg_next   = '0;
                    done_next  = 1'b1;
                    state_next = MF_IDLE;
                end
                else
                begin
                    prod_next  = mul_a * mul_b;
                    state_next = MF_MUL;
                end
            end
            MF_MUL:
            begin
                div_start  = 1'b1;
                state_next = MF_DIV;
            end
            MF_DIV:
            begin
                if (div_done)
                begin
                    if (!ent_reg.shape)
                    begin
                        state_next = MF_POST;
                    end
                    else if (div_quo[MF_QW-1:BELL_AW] != '0)
                    begin
                        deg_next   = '0;
                        done_next  = 1'b1;
                        state_next = MF_IDLE;
                    end
                    else
                    begin
                        state_next = MF_ROM;
                    end
                end
            end
            MF_POST:
            begin
                deg_next   = (div_quo >= peak_ext) ? '0 : 16'(peak_ext - div_quo);
                done_next  = 1'b1;
                state_next = MF_IDLE;
            end
            MF_ROM:
            begin
                mul_a      = ent_reg.peak;
                mul_b      = rom_reg;
                prod_next  = mul_a * mul_b;
                state_next = MF_SCALE;
            end
            MF_SCALE:
            begin
                deg_next   = prod_reg[30:15];
                done_next  = 1'b1;
                state_next = MF_IDLE;
            end
            default:
            begin
                state_next = MF_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MF_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        d_reg    <= d_next;
        prod_reg <= prod_next;
        deg_reg  <= deg_next;
        rom_reg  <= BELL_ROM[div_quo[BELL_AW-1:0]];
    end

    fmmc_div #(
        .DW (MF_DW),
        .QW (MF_QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .den      (div_den),
        .rem_init (div_rem),
        .lo_init  (div_lo),
        .steps    (div_steps),
        .busy     (),
        .done     (div_done),
        .quo      (div_quo)
    );

    assign rsp.busy   = (state_reg != MF_IDLE);
    assign rsp.done   = done_reg;
    assign rsp.degree = deg_reg;

endmodule

// ===== rtl/core/fuzzy_min_max_centroid_inference.sv =====
// load word: result registered in the cycle after acceptance. inference: clear the strength table,
// then per rule two membership degrees and an update of the output set's strength, then per sample
// point a degree for each set with nonzero strength, then the centroid division; one word at a time,
// membership unit is shared. reset clears control and config (rule_count 0, sample_step 13,
// sample_count 300); tables hold garbage until loaded
module fuzzy_min_max_centroid_inference #(
    parameter int NUM_SETS    = fmmc_pkg::NUM_SETS_DEF,
    parameter int MAX_RULES   = fmmc_pkg::MAX_RULES_DEF,
    parameter int MAX_SAMPLES = fmmc_pkg::MAX_SAMPLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [3:0]  slot,
    input  logic        mf_shape,
    input  logic [14:0] mf_width,
    input  logic signed [15:0] mf_center,
    input  logic [15:0] mf_peak,
    input  logic [3:0]  rule_first_set,
    input  logic [3:0]  rule_second_set,
    input  logic [3:0]  rule_out_set,
    input  logic signed [15:0] crisp_first,
    input  logic signed [15:0] crisp_second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  item_kind,
    output logic signed [15:0] crisp_out,
    output logic        area_zero,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    import fmmc_pkg::*;

`include "fuzzy_min_max_centroid_inference_macros.svh"

    localparam int SW    = $clog2(NUM_SETS);
    localparam int RW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int RCW   = $clog2(MAX_RULES + 1);
    localparam int ICW   = $clog2(MAX_SAMPLES + 1);
    localparam int XW    = $clog2(MAX_SAMPLES) + 15;
    localparam int XBITS = XW + 1;
    localparam int BW    = XW + 1;
    localparam int TW    = XW + 16 + $clog2(MAX_SAMPLES) + 1;
    localparam int PW    = XW + 16;
    localparam int DCW   = $clog2(CTR_QW + 1);

    typedef enum logic [17:0] {
        ST_IDLE  = 18'b1,
        ST_CLR   = 18'b1 << 1,
        ST_RRULE = 18'b1 << 2,
        ST_RMF1  = 18'b1 << 3,
        ST_RU1   = 18'b1 << 4,
        ST_RW1   = 18'b1 << 5,
        ST_RU2   = 18'b1 << 6,
        ST_RW2   = 18'b1 << 7,
        ST_RUPD  = 18'b1 << 8,
        ST_SRD   = 18'b1 << 9,
        ST_SCHK  = 18'b1 << 10,
        ST_SWAIT = 18'b1 << 11,
        ST_SMUL  = 18'b1 << 12,
        ST_SACC  = 18'b1 << 13,
        ST_DPREP = 18'b1 << 14,
        ST_DCHK  = 18'b1 << 15,
        ST_DWAIT = 18'b1 << 16,
        ST_DONE  = 18'b1 << 17
    } state_t;

    // tables
    mship_t      mf_mem   [NUM_SETS];
    rule_t       rule_mem [MAX_RULES];
    logic [15:0] str_mem  [NUM_SETS];
    mship_t      mf_q;
    rule_t       rule_q;
    logic [15:0] str_q;

    logic          mf_we, rule_we, str_we;
    logic [SW-1:0] mf_waddr, mf_raddr, str_waddr, str_raddr;
    logic [RW-1:0] rule_waddr, rule_raddr;
    mship_t        mf_wdata;
    rule_t         rule_wdata;
    logic [15:0]   str_wdata;

    state_t             state_reg, state_next;
    logic [SW-1:0]      s_reg, s_next;
    logic [RCW-1:0]     r_reg, r_next;
    logic [ICW-1:0]     i_reg, i_next;
    logic [XW-1:0]      x_reg, x_next;
    logic [15:0]        mu_reg, mu_next;
    logic [15:0]        a_reg, a_next;
    logic [15:0]        b_reg, b_next;
    logic [TW-1:0]      top_reg, top_next;
    logic [BW-1:0]      bottom_reg, bottom_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic [TW:0]        num_reg, num_next;
    logic [15:0]        res_reg, res_next;
    logic               resz_reg, resz_next;
    logic signed [15:0] c1_reg, c1_next;
    logic signed [15:0] c2_reg, c2_next;
    logic [4:0]         rule_count_reg;
    logic [14:0]        step_reg;
    logic [9:0]         count_reg;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [15:0]        crisp_reg, crisp_next;
    logic               zero_reg, zero_next;

    logic [RCW-1:0]     nr;
    logic [ICW-1:0]     ns;
    logic               in_acc;
    logic               first_ok, second_ok, out_ok;
    logic [15:0]        mn, dg;

    mf_req_t                 mf_req;
    mf_rsp_t                 mf_rsp;
    logic signed [XBITS-1:0] mf_x;

    logic               div_start, div_busy, div_done;
    logic [BW-1:0]      div_rem;
    logic [CTR_QW-1:0]  div_lo, div_quo;

    assign nr = (int'(rule_count_reg) > MAX_RULES) ? RCW'(MAX_RULES) : RCW'(rule_count_reg);
    assign ns = (int'(count_reg) > MAX_SAMPLES) ? ICW'(MAX_SAMPLES) : ICW'(count_reg);

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign first_ok  = int'(rule_q.first) < NUM_SETS;
    assign second_ok = int'(rule_q.second) < NUM_SETS;
    assign out_ok    = int'(rule_q.outset) < NUM_SETS;
    assign mn        = (a_reg < b_reg) ? a_reg : b_reg;
    assign dg        = (mf_rsp.degree > str_q) ? str_q : mf_rsp.degree;

    assign div_rem   = BW'(num_reg >> CTR_QW);
    assign div_lo    = num_reg[CTR_QW-1:0];

    always_comb
    begin
        state_next  = state_reg;
        s_next      = s_reg;
        r_next      = r_reg;
        i_next      = i_reg;
        x_next      = x_reg;
        mu_next     = mu_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        prod_next   = prod_reg;
        num_next    = num_reg;
        res_next    = res_reg;
        resz_next   = resz_reg;
        c1_next     = c1_reg;
        c2_next     = c2_reg;
        kind_next   = kind_reg;
        crisp_next  = crisp_reg;
        zero_next   = zero_reg;
        out_valid_next = out_valid_reg && !out_ready;

        mf_we      = 1'b0;
        mf_waddr   = SW'(slot);
        mf_wdata   = '{shape: mf_shape,
                       width: (mf_width == '0) ? 15'd1 : mf_width,
                       center: mf_center,
                       peak: (mf_peak > ONE_Q15) ? ONE_Q15 : mf_peak};
        mf_raddr   = s_reg;
        rule_we    = 1'b0;
        rule_waddr = RW'(slot);
        rule_wdata = '{first: rule_first_set, second: rule_second_set,
                       outset: rule_out_set};
        rule_raddr = RW'(r_reg);
        str_we     = 1'b0;
        str_waddr  = s_reg;
        str_wdata  = '0;
        str_raddr  = s_reg;

        mf_req.start = 1'b0;
        mf_req.entry = mf_q;
        mf_x         = XBITS'({1'b0, x_reg});
        div_start    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    c1_next = crisp_first;
                    c2_next = crisp_second;
                    if (func == FUNC_INFER)
                    begin
                        s_next     = '0;
                        state_next = ST_CLR;
                    end
                    else
                    begin
                        mf_we          = (func == FUNC_LOAD_MF) && (int'(slot) < NUM_SETS);
                        rule_we        = (func == FUNC_LOAD_RULE) && (int'(slot) < MAX_RULES);
                        out_valid_next = 1'b1;
                        kind_next      = func;
                        crisp_next     = '0;
                        zero_next      = 1'b0;
                    end
                end
            end
            ST_CLR:
            begin
                str_we = 1'b1;
                if (s_reg == SW'(NUM_SETS - 1))
                begin
                    r_next      = '0;
                    i_next      = '0;
                    x_next      = '0;
                    s_next      = '0;
                    mu_next     = '0;
                    top_next    = '0;
                    bottom_next = '0;
                    if (nr != '0)
                    begin
                        state_next = ST_RRULE;
                    end
                    else if (ns != '0)
                    begin
                        state_next = ST_SRD;
                    end
                    else
                    begin
                        state_next = ST_DPREP;
                    end
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                end
            end
            ST_RRULE:
            begin
                state_next = ST_RMF1;
            end
            ST_RMF1:
            begin
                mf_raddr   = SW'(rule_q.first);
                state_next = ST_RU1;
            end
            ST_RU1:
            begin
                mf_x = XBITS'(c1_reg);
                if (first_ok)
                begin
                    mf_req.start = 1'b1;
                    state_next   = ST_RW1;
                end
                else
                begin
                    a_next     = '0;
                    mf_raddr   = SW'(rule_q.second);
                    state_next = ST_RU2;
                end
            end
            ST_RW1:
            begin
                mf_raddr = SW'(rule_q.second);
                if (mf_rsp.done)
                begin
                    a_next     = mf_rsp.degree;
                    state_next = ST_RU2;
                end
            end
            ST_RU2:
            begin
                mf_x = XBITS'(c2_reg);
                if (second_ok)
                begin
                    mf_req.start = 1'b1;
                    state_next   = ST_RW2;
                end
                else
                begin
                    b_next     = '0;
                    str_raddr  = SW'(rule_q.outset);
                    state_next = ST_RUPD;
                end
            end
            ST_RW2:
            begin
                str_raddr = SW'(rule_q.outset);
                if (mf_rsp.done)
                begin
                    b_next     = mf_rsp.degree;
                    state_next = ST_RUPD;
                end
            end
            ST_RUPD:
            begin
                str_waddr = SW'(rule_q.outset);
                str_wdata = mn;
                str_we    = out_ok && (str_q < mn);
                r_next    = r_reg + 1'b1;
                if (r_reg + 1'b1 == nr)
                begin
                    state_next = (ns != '0) ? ST_SRD : ST_DPREP;
                end
                else
                begin
                    state_next = ST_RRULE;
                end
            end
            ST_SRD:
            begin
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (str_q == '0)
                begin
                    if (s_reg == SW'(NUM_SETS - 1))
                    begin
                        state_next = ST_SMUL;
                    end
                    else
                    begin
                        s_next     = s_reg + 1'b1;
                        state_next = ST_SRD;
                    end
                end
                else
                begin
                    mf_req.start = 1'b1;
                    state_next   = ST_SWAIT;
                end
            end
            ST_SWAIT:
            begin
                if (mf_rsp.done)
                begin
                    if (dg > mu_reg)
                    begin
                        mu_next = dg;
                    end
                    if (s_reg == SW'(NUM_SETS - 1))
                    begin
                        state_next = ST_SMUL;
                    end
                    else
                    begin
                        s_next     = s_reg + 1'b1;
                        state_next = ST_SRD;
                    end
                end
            end
            ST_SMUL:
            begin
                prod_next  = mu_reg * x_reg;
                state_next = ST_SACC;
            end
            ST_SACC:
            begin
                top_next    = top_reg + TW'(prod_reg);
                bottom_next = bottom_reg + BW'(mu_reg);
                x_next      = x_reg + XW'(step_reg);
                i_next      = i_reg + 1'b1;
                mu_next     = '0;
                s_next      = '0;
                state_next  = (i_reg + 1'b1 == ns) ? ST_DPREP : ST_SRD;
            end
            ST_DPREP:
            begin
                if (bottom_reg == '0)
                begin
                    res_next   = '0;
                    resz_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    num_next   = (TW+1)'(top_reg) + (TW+1)'(bottom_reg >> 1);
                    resz_next  = 1'b0;
                    state_next = ST_DCHK;
                end
            end
            ST_DCHK:
            begin
                // quotient of 2^15 or more saturates
                if ((num_reg >> CTR_QW) >= (TW+1)'(bottom_reg))
                begin
                    res_next   = CENTROID_MAX;
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DWAIT;
                end
            end
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    res_next   = 16'(div_quo);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = FUNC_INFER;
                    crisp_next     = res_reg;
                    zero_next      = resz_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mf_we)
        begin
            mf_mem[mf_waddr] <= mf_wdata;
        end
        mf_q <= mf_mem[mf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rule_we)
        begin
            rule_mem[rule_waddr] <= rule_wdata;
        end
        rule_q <= rule_mem[rule_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (str_we)
        begin
            str_mem[str_waddr] <= str_wdata;
        end
        str_q <= str_mem[str_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            rule_count_reg <= '0;
            step_reg       <= STEP_RESET;
            count_reg      <= COUNT_RESET;
            s_reg          <= '0;
            r_reg          <= '0;
            i_reg          <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            s_reg         <= s_next;
            r_reg         <= r_next;
            i_reg         <= i_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RULE_COUNT:   rule_count_reg <= cfg_data[4:0];
                    CFG_SAMPLE_STEP:  step_reg       <= cfg_data;
                    CFG_SAMPLE_COUNT: count_reg      <= cfg_data[9:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        mu_reg     <= mu_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        top_reg    <= top_next;
        bottom_reg <= bottom_next;
        prod_reg   <= prod_next;
        num_reg    <= num_next;
        res_reg    <= res_next;
        resz_reg   <= resz_next;
        c1_reg     <= c1_next;
        c2_reg     <= c2_next;
        kind_reg   <= kind_next;
        crisp_reg  <= crisp_next;
        zero_reg   <= zero_next;
    end

    fmmc_mf #(
        .XBITS (XBITS)
    ) u_mf (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mf_req),
        .x     (mf_x),
        .rsp   (mf_rsp)
    );

    fmmc_div #(
        .DW (BW),
        .QW (CTR_QW)
    ) u_ctr_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .den      (bottom_reg),
        .rem_init (div_rem),
        .lo_init  (div_lo),
        .steps    (DCW'(CTR_QW)),
        .busy     (div_busy),
        .done     (div_done),
        .quo      (div_quo)
    );

    assign out_valid = out_valid_reg;
    assign item_kind = kind_reg;
    assign crisp_out = crisp_reg;
    assign area_zero = zero_reg;

    `FMMC_ASSERT_SAME(a_mf_start_idle, mf_req.start, !mf_rsp.busy, "degree unit restarted while busy")
    `FMMC_ASSERT_SAME(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")
    `FMMC_ASSERT_SAME(a_div_done_wait, div_done, state_reg == ST_DWAIT, "divider result unclaimed")
    `FMMC_ASSERT_NEXT(a_infer_clears, in_acc && (func == FUNC_INFER), state_reg == ST_CLR, "no clear")
    `FMMC_ASSERT_SAME(a_area_sum, (state_reg == ST_DPREP) && (bottom_reg == '0), top_reg == '0, "top without area")

endmodule

// ===== bench/fmmc_scoreboard.sv =====
// checker for the fuzzy inference engine: watches the word, result and register channels,
// predicts each result and compares it; depends on fmmc_pkg
module fmmc_scoreboard (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         func,
    input  logic [3:0]         slot,
    input  logic               mf_shape,
    input  logic [14:0]        mf_width,
    input  logic signed [15:0] mf_center,
    input  logic [15:0]        mf_peak,
    input  logic [3:0]         rule_first_set,
    input  logic [3:0]         rule_second_set,
    input  logic [3:0]         rule_out_set,
    input  logic signed [15:0] crisp_first,
    input  logic signed [15:0] crisp_second,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         item_kind,
    input  logic signed [15:0] crisp_out,
    input  logic               area_zero,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fmmc_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] centroid;
        logic        empty;
    } answer_t;

    answer_t       answers[$];
    mship_t        sets[16];
    rule_t         rules[16];
    logic [4:0]    n_rules;
    logic [14:0]   step;
    logic [9:0]    n_points;
    logic [15:0]   bell_shape[1024];

    initial
    begin
        longint unsigned t;
        longint unsigned acc;
        longint unsigned v;
        errors = 0;
        for (int i = 0; i < 1024; i++)
        begin
            t   = 64'd1 << 32;
            acc = t;
            for (int k = 1; k < 17; k++)
            begin
                t = (t * i) / (1024 * k);
                acc = (k & 1) ? acc - t : acc + t;
            end
            v = (acc * (1024 - i)) / 1024;
            v = (v + (64'd1 << 16)) >> 17;
            bell_shape[i] = (v > 32768) ? 16'd32768 : 16'(v);
        end
    end

    function automatic longint unsigned degree_at(int unsigned s, longint x);
        longint unsigned w;
        longint unsigned d;
        longint unsigned p;
        longint unsigned q;
        longint          diff;
        w    = (sets[s].width == 0) ? 1 : sets[s].width;
        p    = sets[s].peak;
        diff = x - longint'(sets[s].center);
        d    = (diff < 0) ? -diff : diff;
        if (d >= w)
            return 0;
        if (sets[s].shape == 1'b0)
        begin
            q = (2 * p * d) / w;
            return (q >= p) ? 0 : p - q;
        end
        q = (d * d * 4096) / (w * w);
        if (q >= 1024)
            return 0;
        return (p * bell_shape[q]) >> 15;
    endfunction

    function automatic answer_t infer(longint c1, longint c2);
        answer_t         a;
        longint unsigned fire[16];
        longint unsigned m1;
        longint unsigned m2;
        longint unsigned mu;
        longint unsigned dg;
        longint unsigned top;
        longint unsigned bottom;
        longint unsigned c;
        longint          x;
        int              nr;
        int              np;
        a.kind = FUNC_INFER;
        a.centroid = 0;
        a.empty = 0;
        for (int s = 0; s < 16; s++)
            fire[s] = 0;
        nr = (n_rules > 16) ? 16 : n_rules;
        np = (n_points > 512) ? 512 : n_points;
        for (int r = 0; r < nr; r++)
        begin
            m1 = degree_at(rules[r].first, c1);
            m2 = degree_at(rules[r].second, c2);
            if (m2 < m1)
                m1 = m2;
            if (fire[rules[r].outset] < m1)
                fire[rules[r].outset] = m1;
        end
        top = 0;
        bottom = 0;
        for (int i = 0; i < np; i++)
        begin
            x  = longint'(i) * longint'(step);
            mu = 0;
            for (int s = 0; s < 16; s++)
            begin
                if (fire[s] != 0)
                begin
                    dg = degree_at(s, x);
                    if (dg > fire[s])
                        dg = fire[s];
                    if (dg > mu)
                        mu = dg;
                end
            end
            top += mu * longint'(x);
            bottom += mu;
        end
        if (bottom == 0)
            a.empty = 1;
        else
        begin
            c = (top + bottom / 2) / bottom;
            a.centroid = (c > 32767) ? CENTROID_MAX : 16'(c);
        end
        return a;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("result %s differs: got %0d, predicted %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t a;
        if (!rst_n)
        begin
            n_rules  = 0;
            step     = STEP_RESET;
            n_points = COUNT_RESET;
            answers.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RULE_COUNT:   n_rules  = cfg_data[4:0];
                    CFG_SAMPLE_STEP:  step     = cfg_data;
                    CFG_SAMPLE_COUNT: n_points = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                a.kind = func;
                a.centroid = 0;
                a.empty = 0;
                case (func)
                    FUNC_LOAD_MF:
                    begin
                        sets[slot].shape  = mf_shape;
                        sets[slot].width  = mf_width;
                        sets[slot].center = mf_center;
                        sets[slot].peak   = (mf_peak > ONE_Q15) ? ONE_Q15 : mf_peak;
                    end
                    FUNC_LOAD_RULE:
                    begin
                        rules[slot].first  = rule_first_set;
                        rules[slot].second = rule_second_set;
                        rules[slot].outset = rule_out_set;
                    end
                    FUNC_INFER: a = infer(crisp_first, crisp_second);
                    default: ;
                endcase
                answers.push_back(a);
            end
            if (out_valid && out_ready)
            begin
                if (answers.size() == 0)
                begin
                    $display("result word with nothing predicted at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    a = answers.pop_front();
                    if (item_kind !== a.kind)
                        report("item_kind", item_kind, a.kind);
                    if (crisp_out !== a.centroid)
                        report("crisp_out", crisp_out, a.centroid);
                    if (area_zero !== a.empty)
                        report("area_zero", area_zero, a.empty);
                end
            end
        end
        pending = answers.size();
    end
endmodule

// ===== bench/tb_fuzzy_min_max_centroid_inference.sv =====
// top of the fuzzy inference bench: clock, reset, word and register stimulus, verdict
// depends on fmmc_pkg, the engine rtl and fmmc_scoreboard
module tb_fuzzy_min_max_centroid_inference;
    timeunit 1ns;
    timeprecision 1ps;
    import fmmc_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam logic [1:0] CFG_SPARE  = 2'd3;
    localparam longint     CYCLE_LIMIT = 40_000_000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         func;
    logic [3:0]         slot;
    logic               mf_shape;
    logic [14:0]        mf_width;
    logic signed [15:0] mf_center;
    logic [15:0]        mf_peak;
    logic [3:0]         rule_first_set;
    logic [3:0]         rule_second_set;
    logic [3:0]         rule_out_set;
    logic signed [15:0] crisp_first;
    logic signed [15:0] crisp_second;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         item_kind;
    logic signed [15:0] crisp_out;
    logic               area_zero;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [14:0]        cfg_data;
    int                 errors;
    int                 pending;
    longint             cycles;
    bit                 calm;
    int                 span;

    fuzzy_min_max_centroid_inference dut (.*);
    fmmc_scoreboard checker_i (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fuzzy_min_max_centroid_inference: mismatch");
            $finish;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // result side stalls independently of the word side
    initial
    begin
        int g;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            g = draw_gap();
            if (g > 0)
            begin
                out_ready = 0;
                repeat (g) @(negedge clk);
            end
            out_ready = 1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // fields are taken from the low bits of each argument
    task automatic send_word(int unsigned f, int unsigned s, int unsigned sh, int unsigned w,
                             int unsigned c, int unsigned p, int unsigned r1,
                             int unsigned r2, int unsigned ro, int unsigned x1,
                             int unsigned x2);
        int g;
        g = draw_gap();
        if (g > 0)
        begin
            in_valid = 0;
            repeat (g) @(negedge clk);
        end
        func = 2'(f); slot = 4'(s); mf_shape = 1'(sh); mf_width = 15'(w);
        mf_center = 16'(c); mf_peak = 16'(p);
        rule_first_set = 4'(r1); rule_second_set = 4'(r2); rule_out_set = 4'(ro);
        crisp_first = 16'(x1); crisp_second = 16'(x2);
        in_valid = 1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        span++;
        if (span % 60 == 0)
            calm = !calm;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [14:0] value);
        in_valid = 0;
        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic setup(int nr, int st, int np);
        write_reg(CFG_RULE_COUNT, 15'(nr));
        write_reg(CFG_SAMPLE_STEP, 15'(st));
        write_reg(CFG_SAMPLE_COUNT, 15'(np));
    endtask

    task automatic load_set(int s, int hi);
        logic [15:0] pk;
        pk = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        if ($urandom_range(0, 7) == 0)
            send_word(FUNC_LOAD_MF, 4'(s), $urandom, $urandom, $urandom, pk, 0, 0, 0, 0, 0);
        else
            send_word(FUNC_LOAD_MF, 4'(s), $urandom, 15'($urandom_range(1, hi)),
                      16'($urandom_range(0, hi)), pk, 0, 0, 0, 0, 0);
    endtask

    task automatic random_block(int n, int hi);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 25)
                load_set($urandom_range(0, 15), hi);
            else if (k < 50)
                send_word(FUNC_LOAD_RULE, $urandom, 0, 1, 0, 0, $urandom, $urandom, $urandom,
                          0, 0);
            else if (k < 95)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word(FUNC_INFER, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom);
                else
                    send_word(FUNC_INFER, 0, 0, 1, 0, 0, 0, 0, 0,
                              16'($urandom_range(0, hi)), 16'($urandom_range(0, hi)));
            end
            else
                send_word(FUNC_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        int st;
        int np;
        int hi;
        cycles = 0;
        calm = 0;
        span = 0;
        in_valid = 0;
        cfg_valid = 0;
        cfg_index = CFG_RULE_COUNT;
        cfg_data = 0;
        func = FUNC_LOAD_MF; slot = 0; mf_shape = 0; mf_width = 1; mf_center = 0;
        mf_peak = 0; rule_first_set = 0; rule_second_set = 0; rule_out_set = 0;
        crisp_first = 0; crisp_second = 0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // every table entry is written before any inference reads it
        send_word(FUNC_LOAD_MF, 0, 0, 15'd1, 16'h8000, 16'd0, 0, 0, 0, 0, 0);
        send_word(FUNC_LOAD_MF, 1, 1, 15'h7FFF, 16'h7FFF, 16'hFFFF, 0, 0, 0, 0, 0);
        send_word(FUNC_LOAD_MF, 2, 0, 15'd0, 16'd0, 16'd32768, 0, 0, 0, 0, 0);
        send_word(FUNC_LOAD_MF, 3, 1, 15'd0, 16'd0, 16'd32769, 0, 0, 0, 0, 0);
        for (int s = 4; s < 16; s++)
            load_set(s, 4000);
        for (int r = 0; r < 16; r++)
            send_word(FUNC_LOAD_RULE, 4'(r), 0, 1, 0, 0, $urandom, $urandom, $urandom, 0, 0);
        send_word(FUNC_INFER, 0, 0, 1, 0, 0, 0, 0, 0, 16'h8000, 16'h7FFF);
        send_word(FUNC_SPARE, 4'hF, 1, 15'h7FFF, 16'hFFFF, 16'hFFFF, 4'hF, 4'hF, 4'hF,
                  16'hFFFF, 16'hFFFF);

        setup(16, 1, 2);
        send_word(FUNC_INFER, 0, 0, 1, 0, 0, 0, 0, 0, 16'd0, 16'd0);
        send_word(FUNC_INFER, 0, 0, 1, 0, 0, 0, 0, 0, 16'd1, 16'd200);
        setup(31, 32767, 512);
        send_word(FUNC_INFER, 0, 0, 1, 0, 0, 0, 0, 0, 16'd100, 16'd3000);
        setup(1, 20, 1023);
        write_reg(CFG_SPARE, 15'h7FFF);
        send_word(FUNC_INFER, 0, 0, 1, 0, 0, 0, 0, 0, 16'd300, 16'd900);
        setup(16, 500, 0);
        send_word(FUNC_INFER, 0, 0, 1, 0, 0, 0, 0, 0, 16'd300, 16'd900);

        for (int b = 0; b < 14; b++)
        begin
            st = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 32767)
                                             : $urandom_range(50, 3000);
            np = $urandom_range(2, 6);
            hi = st * np;
            if (hi > 32767)
                hi = 32767;
            setup((b % 4 == 0) ? 16 : $urandom_range(0, 16), st, np);
            random_block(100, hi);
        end

        in_valid = 0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("fuzzy_min_max_centroid_inference: match");
        else
            $display("fuzzy_min_max_centroid_inference: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/fmmc_pkg.sv
rtl/core/fmmc_div.sv
rtl/core/fmmc_mf.sv
rtl/core/fuzzy_min_max_centroid_inference.sv
bench/fmmc_scoreboard.sv
bench/tb_fuzzy_min_max_centroid_inference.sv
